FILE: rtl/core/dmc_pkg.sv
// dmc_pkg: shared types, codes and constants of the depth-first maze carver
// used by dfs_maze_carver_top; depends on nothing else
package dmc_pkg;

  localparam int MAX_SIDE_DEF    = 64;
  localparam int STACK_DEPTH_DEF = 1024;

  localparam int COORD_W  = 6;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] GRID_SIDE_RESET = 7'd31;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;

  localparam logic [1:0] CELL_EMPTY = 2'd0;
  localparam logic [1:0] CELL_WALL  = 2'd1;
  localparam logic [1:0] CELL_START = 2'd2;
  localparam logic [1:0] CELL_END   = 2'd3;

  localparam logic [2:0] EV_STARTED      = 3'd0;
  localparam logic [2:0] EV_CARVED       = 3'd1;
  localparam logic [2:0] EV_BACKTRACKED  = 3'd2;
  localparam logic [2:0] EV_FINISHED     = 3'd3;
  localparam logic [2:0] EV_READ_DATA    = 3'd4;
  localparam logic [2:0] EV_ALREADY_DONE = 3'd5;

  // neighbor offsets two cells away, order up, right, down, left
  localparam logic signed [2:0] STEP_DX [4] = '{3'sd0, 3'sd2, 3'sd0, -3'sd2};
  localparam logic signed [2:0] STEP_DY [4] = '{-3'sd2, 3'sd0, 3'sd2, 3'sd0};
  // offsets of the wall cell in between
  localparam logic signed [2:0] MID_DX  [4] = '{3'sd0, 3'sd1, 3'sd0, -3'sd1};
  localparam logic signed [2:0] MID_DY  [4] = '{-3'sd1, 3'sd0, 3'sd1, 3'sd0};

  typedef struct packed {
    logic [1:0]         operation;
    logic [1:0]         random_draw;
    logic [COORD_W-1:0] read_x;
    logic [COORD_W-1:0] read_y;
  } in_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic [COORD_W-1:0] next_x;
    logic [COORD_W-1:0] next_y;
    logic [COORD_W-1:0] wall_x;
    logic [COORD_W-1:0] wall_y;
    logic [1:0]         cell_value;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_START,
    ST_IDLE,
    ST_READ,
    ST_CUR,
    ST_NB,
    ST_LAST,
    ST_PLACE,
    ST_FIN,
    ST_RESP
  } state_t;

endpackage

FILE: rtl/core/dmc_ram.sv
// dmc_ram: generic simple dual-port ram, one write and one registered read port
// standalone, no package needed
module dmc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/dfs_maze_carver_top.sv
// dfs_maze_carver_top: depth-first maze carver, cell grid and path stack in dmc_ram
// depends on dmc_pkg and dmc_ram; one item in flight at a time
// a start reruns the clearing sweep over the grid ram, 4096 entries at default;
// a carving or backtracking step reads the four neighbors from the grid ram in series
// reset: sync, stack empty, done set, then the clearing sweep with in_ready low
module dfs_maze_carver_top #(
  parameter int MAX_SIDE    = dmc_pkg::MAX_SIDE_DEF,
  parameter int STACK_DEPTH = dmc_pkg::STACK_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [dmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dmc_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  dmc_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output dmc_pkg::out_t                   out_data
);

  import dmc_pkg::*;

  localparam int CW   = $clog2(MAX_SIDE);
  localparam int SW   = CW + 1;
  localparam int NW   = CW + 2;
  localparam int CMPW = (SW > CFG_W) ? SW : CFG_W;
  localparam int GAW  = 2 * CW;
  localparam int SAW  = $clog2(STACK_DEPTH);
  localparam int CNTW = $clog2(STACK_DEPTH + 1);

  state_t state, state_next;

  logic [CFG_W-1:0] grid_width, grid_height;
  logic [SW-1:0]    w, h;

  logic [CNTW-1:0] count;
  logic            done;
  logic [GAW-1:0]  clr_addr;
  logic            clr_start;
  logic [1:0]      k;
  logic [2:0]      seen;
  logic [CW-1:0]   cur_x, cur_y, pk_x, pk_y;
  logic            rd_in;
  logic [1:0]      draw;
  out_t            res;

  // ram ports
  logic            cell_we;
  logic [GAW-1:0]  cell_waddr, cell_raddr;
  logic [1:0]      cell_wdata, cell_rdata;
  logic            stk_we;
  logic [SAW-1:0]  stk_waddr, stk_raddr;
  logic [GAW-1:0]  stk_wdata, stk_rdata;

  // neighbor geometry
  logic signed [NW-1:0] px [4];
  logic signed [NW-1:0] py [4];
  logic [CW-1:0] nb_x [4];
  logic [CW-1:0] nb_y [4];
  logic [CW-1:0] mid_x [4];
  logic [CW-1:0] mid_y [4];
  logic [3:0]    nb_ok;
  logic [3:0]    cand;
  logic [2:0]    n_cand;
  logic [1:0]    ord;
  logic [1:0]    sel;
  logic          carve;
  logic          stack_room;
  logic          out_free;

  dmc_ram #(.WIDTH(2), .DEPTH(1 << GAW)) u_cells (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  dmc_ram #(.WIDTH(GAW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // clamp sides to [3, MAX_SIDE]
  always_comb begin
    if (grid_width < CFG_W'(3)) w = SW'(3);
    else if (CMPW'(grid_width) > CMPW'(MAX_SIDE)) w = SW'(MAX_SIDE);
    else w = SW'(grid_width);
    if (grid_height < CFG_W'(3)) h = SW'(3);
    else if (CMPW'(grid_height) > CMPW'(MAX_SIDE)) h = SW'(MAX_SIDE);
    else h = SW'(grid_height);
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      px[i]    = $signed({2'b00, cur_x}) + NW'(STEP_DX[i]);
      py[i]    = $signed({2'b00, cur_y}) + NW'(STEP_DY[i]);
      nb_x[i]  = CW'(px[i]);
      nb_y[i]  = CW'(py[i]);
      mid_x[i] = CW'($signed({2'b00, cur_x}) + NW'(MID_DX[i]));
      mid_y[i] = CW'($signed({2'b00, cur_y}) + NW'(MID_DY[i]));
      nb_ok[i] = (px[i] > 0) && (px[i] < $signed({1'b0, w}) - 1) &&
                 (py[i] > 0) && (py[i] < $signed({1'b0, h}) - 1);
    end
  end

  // candidate pick: random_draw modulo the candidate count, in direction order
  always_comb begin
    logic [2:0] seen_cnt;
    logic       found;
    seen_cnt = '0;
    found    = 1'b0;
    sel      = '0;
    cand     = nb_ok & {cell_rdata == CELL_WALL, seen};
    n_cand   = 3'($countones(cand));
    carve    = |cand;
    unique case (n_cand)
      3'd1:    ord = 2'd0;
      3'd2:    ord = {1'b0, draw[0]};
      3'd3:    ord = (draw == 2'd3) ? 2'd0 : draw;
      default: ord = draw;
    endcase
    for (int i = 0; i < 4; i++) begin
      if (cand[i]) begin
        if (!found && seen_cnt == {1'b0, ord}) begin
          sel   = 2'(i);
          found = 1'b1;
        end
        seen_cnt = seen_cnt + 3'd1;
      end
    end
  end

  assign stack_room = (count < CNTW'(STACK_DEPTH));
  assign out_free   = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (&clr_addr) state_next = clr_start ? ST_START : ST_IDLE;
      ST_START: state_next = ST_RESP;
      ST_IDLE: begin
        if (in_valid) begin
          priority if (in_data.operation == OP_START) state_next = ST_CLEAR;
          else if (in_data.operation == OP_STEP)
            state_next = (done || count == '0) ? ST_RESP : ST_CUR;
          else state_next = ST_READ;
        end
      end
      ST_READ:  state_next = ST_RESP;
      ST_CUR:   state_next = ST_NB;
      ST_NB:    if (k == 2'd3) state_next = ST_LAST;
      ST_LAST: begin
        if (carve) state_next = ST_PLACE;
        else if (count == CNTW'(1)) state_next = ST_FIN;
        else state_next = ST_RESP;
      end
      ST_PLACE: state_next = ST_RESP;
      ST_FIN:   state_next = ST_RESP;
      ST_RESP:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // ram controls and handshake
  always_comb begin
    in_ready   = (state == ST_IDLE);
    cell_we    = 1'b0;
    cell_waddr = '0;
    cell_wdata = CELL_EMPTY;
    cell_raddr = '0;
    stk_we     = 1'b0;
    stk_waddr  = '0;
    stk_wdata  = '0;
    stk_raddr  = SAW'(count - CNTW'(1));
    unique case (state)
      ST_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_addr;
        cell_wdata = CELL_WALL;
      end
      ST_START: begin
        cell_we    = 1'b1;
        cell_waddr = {CW'(1), CW'(1)};
        stk_we     = 1'b1;
        stk_wdata  = {CW'(1), CW'(1)};
      end
      ST_IDLE: cell_raddr = {CW'(in_data.read_y), CW'(in_data.read_x)};
      ST_NB:   cell_raddr = {nb_y[k], nb_x[k]};
      ST_LAST: begin
        if (carve) begin
          cell_we    = 1'b1;
          cell_waddr = {mid_y[sel], mid_x[sel]};
        end else if (count == CNTW'(1)) begin
          cell_we    = 1'b1;
          cell_waddr = {CW'(1), CW'(1)};
          cell_wdata = CELL_START;
        end
      end
      ST_PLACE: begin
        cell_we    = 1'b1;
        cell_waddr = {pk_y, pk_x};
        stk_we     = stack_room;
        stk_waddr  = SAW'(count);
        stk_wdata  = {pk_y, pk_x};
      end
      ST_FIN: begin
        cell_we    = 1'b1;
        cell_waddr = {CW'(h - SW'(2)), CW'(w - SW'(2))};
        cell_wdata = CELL_END;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      grid_width  <= GRID_SIDE_RESET;
      grid_height <= GRID_SIDE_RESET;
      count       <= '0;
      done        <= 1'b1;
      clr_addr    <= '0;
      clr_start   <= 1'b0;
      k           <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_GRID_WIDTH:  grid_width  <= cfg_data;
          REG_GRID_HEIGHT: grid_height <= cfg_data;
        endcase
      end
      if (state == ST_RESP && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: clr_addr <= clr_addr + GAW'(1);
        ST_START: begin
          count     <= CNTW'(1);
          done      <= 1'b0;
          clr_start <= 1'b0;
        end
        ST_IDLE: begin
          if (in_valid) begin
            priority if (in_data.operation == OP_START) begin
              clr_addr  <= '0;
              clr_start <= 1'b1;
            end else if (in_data.operation == OP_STEP) begin
              if (done || count == '0) done <= 1'b1;
            end
          end
        end
        ST_CUR: k <= '0;
        ST_NB: begin
          if (k != 2'd0) seen[k - 2'd1] <= (cell_rdata == CELL_WALL);
          k <= k + 2'd1;
        end
        ST_LAST: if (!carve) count <= count - CNTW'(1);
        ST_PLACE: if (stack_room) count <= count + CNTW'(1);
        ST_FIN: done <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    unique case (state)
      ST_START: res <= '{EV_STARTED, COORD_W'(1), COORD_W'(1), '0, '0, CELL_EMPTY};
      ST_IDLE: begin
        rd_in <= (CMPW'(in_data.read_x) < CMPW'(w)) && (CMPW'(in_data.read_y) < CMPW'(h));
        draw  <= in_data.random_draw;
        res   <= '{EV_ALREADY_DONE, '0, '0, '0, '0, CELL_EMPTY};
      end
      ST_READ: res <= '{EV_READ_DATA, '0, '0, '0, '0, rd_in ? cell_rdata : CELL_WALL};
      ST_CUR: begin
        cur_x <= stk_rdata[CW-1:0];
        cur_y <= stk_rdata[GAW-1:CW];
      end
      ST_LAST: begin
        pk_x <= nb_x[sel];
        pk_y <= nb_y[sel];
        if (carve) begin
          res <= '{EV_CARVED, COORD_W'(nb_x[sel]), COORD_W'(nb_y[sel]),
                   COORD_W'(mid_x[sel]), COORD_W'(mid_y[sel]), CELL_EMPTY};
        end else begin
          res <= '{EV_BACKTRACKED, '0, '0, '0, '0, CELL_EMPTY};
        end
      end
      ST_FIN: res <= '{EV_FINISHED, '0, '0, '0, '0, CELL_EMPTY};
      ST_RESP: if (out_free) out_data <= res;
      default: ;
    endcase
  end

  // no grid write while a neighbor read sweep is under way
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CUR || state == ST_NB) |-> !cell_we)
    else $error("grid write during neighbor reads");

  assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_START) |=> (count == CNTW'(1) && !done))
    else $error("start did not seed the stack");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CUR) |-> (!done && count != '0))
    else $error("carving step on empty or finished maze");

endmodule
